// File: design/ptw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptw_pkg
// Shared types and codes of the four-level page table walker.
// ----------------------------------------------------------------------------
package ptw_pkg;

	// table entry as stored: bits 63..52 of an x86-64 entry are not stored here
	localparam int ENTRY_W = 52;
	localparam int FRAME_W = 40;
	localparam int IDX_W   = 9;
	localparam int BASE_W  = 52;

	// request codes
	localparam logic ACT_MAP   = 1'b0;
	localparam logic ACT_XLATE = 1'b1;

	// result status codes
	localparam logic [1:0] STATUS_OK          = 2'd0;
	localparam logic [1:0] STATUS_NOT_PRESENT = 2'd1;
	localparam logic [1:0] STATUS_NO_PAGE     = 2'd2;

	// walk levels
	localparam logic [1:0] LVL_PML4 = 2'd0;
	localparam logic [1:0] LVL_PDPT = 2'd1;
	localparam logic [1:0] LVL_PD   = 2'd2;
	localparam logic [1:0] LVL_LEAF = 2'd3;

	typedef struct packed {
		logic        action;
		logic [47:0] virt_addr;
		logic [51:0] phys_addr;
		logic [11:0] page_flags;
	} ptw_req_t;

	typedef struct packed {
		logic [51:0] phys_result;
		logic [1:0]  status;
	} ptw_rsp_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_EVAL
	} ptw_state_t;

endpackage

// File: design/four_level_page_table_walker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_level_page_table_walker
// Map and translate requests over an on-chip four-level page table store.
// ----------------------------------------------------------------------------
// After reset the block sweeps the table store to zero, one entry per cycle,
// and busy stays high until the sweep is through, before the first item is
// taken. Each level of a walk reads the entry through the store's single
// read port in ST_READ and checks it in ST_EVAL, where map also writes a new
// entry for a missing level; map writes its leaf entry in ST_READ. An item
// that fails at an upper level ends its walk there. done is high for one
// cycle with the result and busy is already low in that cycle, so the next
// item can start there. The receiver cannot stall the result.
// ----------------------------------------------------------------------------
module four_level_page_table_walker import ptw_pkg::*; #(
	parameter int TABLE_PAGES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  ptw_req_t    req,
	output logic        done,
	output ptw_rsp_t    rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	localparam int AW    = $clog2(TABLE_PAGES) + IDX_W;
	localparam int DEPTH = TABLE_PAGES * 512;

	logic [BASE_W-1:0]  table_base;
	logic               mem_we, mem_re;
	logic [AW-1:0]      mem_waddr, mem_raddr;
	logic [ENTRY_W-1:0] mem_wdata, mem_rdata;

	// configuration registers
	ptw_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.table_base (table_base)
	);

	// walk sequencer
	ptw_ctrl #(
		.TABLE_PAGES (TABLE_PAGES)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.req        (req),
		.busy       (busy),
		.done       (done),
		.rsp        (rsp),
		.table_base (table_base),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_re     (mem_re),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata)
	);

	// table store
	ptw_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

// File: design/ptw_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptw_mem
// Table store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ptw_mem import ptw_pkg::*; #(
	parameter int DEPTH = 8192,
	parameter int AW    = 13
) (
	input  logic               clk,
	input  logic               we,
	input  logic [AW-1:0]      waddr,
	input  logic [ENTRY_W-1:0] wdata,
	input  logic               re,
	input  logic [AW-1:0]      raddr,
	output logic [ENTRY_W-1:0] rdata
);

	logic [ENTRY_W-1:0] mem [DEPTH];
	logic [ENTRY_W-1:0] rdata_q;

	// synchronous write and read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: design/ptw_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptw_cfg
// Configuration register file: table base address behind an apb port.
// ----------------------------------------------------------------------------
module ptw_cfg import ptw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [63:0]       pwdata,
	output logic [63:0]       prdata,
	output logic              pready,
	output logic [BASE_W-1:0] table_base
);

	logic [BASE_W-1:0] base_q;
	logic              wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && (paddr[3] == 1'b0);

	// table base register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (wr_en) begin
			base_q <= pwdata[BASE_W-1:0];
		end
	end

	// read mux
	always_comb begin
		if (paddr[3] == 1'b0) begin
			prdata = {12'd0, base_q};
		end else begin
			prdata = '0;
		end
	end

	assign table_base = base_q;

endmodule

// File: design/ptw_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptw_ctrl
// Walk sequencer: clears the store, then reads, checks and writes entries
// level by level for each map or translate item.
// ----------------------------------------------------------------------------
module ptw_ctrl import ptw_pkg::*; #(
	parameter int TABLE_PAGES = 16
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        start,
	input  ptw_req_t                                    req,
	output logic                                        busy,
	output logic                                        done,
	output ptw_rsp_t                                    rsp,
	input  logic [BASE_W-1:0]                           table_base,
	output logic                                        mem_we,
	output logic [$clog2(TABLE_PAGES)+IDX_W-1:0]        mem_waddr,
	output logic [ENTRY_W-1:0]                          mem_wdata,
	output logic                                        mem_re,
	output logic [$clog2(TABLE_PAGES)+IDX_W-1:0]        mem_raddr,
	input  logic [ENTRY_W-1:0]                          mem_rdata
);

	localparam int PW    = $clog2(TABLE_PAGES);
	localparam int AW    = PW + IDX_W;
	localparam int DEPTH = TABLE_PAGES * 512;
	localparam int NFW   = $clog2(TABLE_PAGES + 1);

	ptw_state_t         state_q, state_d;
	ptw_req_t           req_q;
	ptw_rsp_t           rsp_q, fin_rsp;
	logic [PW-1:0]      page_q, page_d;
	logic [1:0]         lvl_q;
	logic [NFW-1:0]     nfp_q;
	logic [AW-1:0]      clr_q;
	logic               done_q;
	logic               fin, adv, alloc, accept;
	logic [IDX_W-1:0]   idx;
	logic [AW-1:0]      addr;
	logic [FRAME_W-1:0] diff, new_frame;
	logic               hit, out_of_pages;

	assign accept = start && (state_q == ST_IDLE);

	// index slice of the current level
	always_comb begin
		unique case (lvl_q)
			LVL_PML4: idx = req_q.virt_addr[47:39];
			LVL_PDPT: idx = req_q.virt_addr[38:30];
			LVL_PD:   idx = req_q.virt_addr[29:21];
			LVL_LEAF: idx = req_q.virt_addr[20:12];
			default:  idx = req_q.virt_addr[20:12];
		endcase
	end

	assign addr = {page_q, idx};

	// follow check: present and pointing inside the store under the current base
	assign diff         = mem_rdata[51:12] - table_base[51:12];
	assign hit          = mem_rdata[0] && (diff < FRAME_W'(TABLE_PAGES));
	assign out_of_pages = nfp_q >= NFW'(TABLE_PAGES);
	assign new_frame    = table_base[51:12] + FRAME_W'(nfp_q);

	// next state and memory control
	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = addr;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = addr;
		fin       = 1'b0;
		fin_rsp   = '0;
		adv       = 1'b0;
		alloc     = 1'b0;
		page_d    = page_q;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				if (clr_q == AW'(DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				if (req_q.action == ACT_MAP && lvl_q == LVL_LEAF) begin
					// leaf write: frame, flags, present
					mem_we    = 1'b1;
					mem_wdata = {req_q.phys_addr[51:12], req_q.page_flags[11:1], 1'b1};
					fin       = 1'b1;
					state_d   = ST_IDLE;
				end else begin
					mem_re  = 1'b1;
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				priority if (req_q.action == ACT_XLATE && lvl_q == LVL_LEAF) begin
					fin     = 1'b1;
					state_d = ST_IDLE;
					if (mem_rdata[0]) begin
						fin_rsp.phys_result = {mem_rdata[51:12], req_q.virt_addr[11:0]};
					end else begin
						fin_rsp.status = STATUS_NOT_PRESENT;
					end
				end else if (hit) begin
					adv     = 1'b1;
					page_d  = diff[PW-1:0];
					state_d = ST_READ;
				end else if (req_q.action == ACT_XLATE) begin
					fin            = 1'b1;
					fin_rsp.status = STATUS_NOT_PRESENT;
					state_d        = ST_IDLE;
				end else if (out_of_pages) begin
					fin            = 1'b1;
					fin_rsp.status = STATUS_NO_PAGE;
					state_d        = ST_IDLE;
				end else begin
					// entry missing or pointing outside the store: take a fresh page, present and writable
					mem_we    = 1'b1;
					mem_wdata = {new_frame, 10'd0, 2'b11};
					alloc     = 1'b1;
					adv       = 1'b1;
					page_d    = nfp_q[PW-1:0];
					state_d   = ST_READ;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			nfp_q   <= NFW'(1);
			done_q  <= 1'b0;
			lvl_q   <= LVL_PML4;
			page_q  <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (alloc) begin
				nfp_q <= nfp_q + NFW'(1);
			end
			if (accept) begin
				lvl_q  <= LVL_PML4;
				page_q <= '0;
			end else if (adv) begin
				lvl_q  <= lvl_q + 2'd1;
				page_q <= page_d;
			end
		end
	end

	// item and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if (fin) begin
			rsp_q <= fin_rsp;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

// File: design/ptw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptw_checker
// Port-level checks of the walker's item handshake and results.
// ----------------------------------------------------------------------------
module ptw_checker import ptw_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     start,
	input logic     busy,
	input logic     done,
	input ptw_rsp_t rsp
);

	// an accepted item keeps the block busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("block not busy after accepting an item");

	// a result shows only when the block is free again
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	// the result strobe does not repeat back to back
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	// failing results carry a zero address; map results are zero too but not checked
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status != STATUS_OK |-> rsp.phys_result == '0)
		else $error("nonzero address with failing status");

endmodule

bind four_level_page_table_walker ptw_checker u_ptw_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);
